@@ design/b32rg_pkg.sv @@
// shared types and constants for the base32 symbol regrouper
`default_nettype none

package b32rg_pkg;

  localparam int ACC_W = 12;
  localparam int CNT_W = 17;
  localparam int LEN_W = 16;

  // register indexes
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  // mode codes
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // (len + 4) / 5 by reciprocal: exact for any 17-bit dividend
  localparam int          DIV5_SHIFT = 22;
  localparam logic [19:0] DIV5_RECIP = 20'd838861;

  localparam logic [3:0] MAX_RES = 4'd8;

  typedef logic [3:0] cmd_t;

  localparam cmd_t CMD_NONE    = 4'd0;
  localparam cmd_t CMD_CAPTURE = 4'd1;
  localparam cmd_t CMD_SYMLEN  = 4'd2;
  localparam cmd_t CMD_ABSORB  = 4'd3;
  localparam cmd_t CMD_GROUP   = 4'd4;
  localparam cmd_t CMD_FLUSH   = 4'd5;
  localparam cmd_t CMD_ZERO    = 4'd6;
  localparam cmd_t CMD_BYTE    = 4'd7;
  localparam cmd_t CMD_CLEAR   = 4'd8;

  typedef struct packed {
    logic mode;
    logic skip;
    logic bc_ge5;
    logic bc_ge8;
    logic bc_part;
    logic enc_last;
    logic dec_last;
    logic pad_more;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ design/b32rg_dp.sv @@
// datapath: config registers, bit accumulator, counters and result register
`default_nettype none

module b32rg_dp
  import b32rg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic             wr_index,
  input  wire logic [LEN_W-1:0] wr_data,
  input  wire logic [7:0]       value,
  input  wire cmd_t             cmd,
  output status_t               status,
  output logic [7:0]            value_res,
  output logic                  last,
  output logic                  res_valid,
  input  wire logic             res_stall
);

  logic             mode;
  logic [LEN_W-1:0] message_length;
  logic [7:0]       word;
  logic [CNT_W-1:0] sym_len;
  logic [ACC_W-1:0] acc;
  logic [3:0]       bc;
  logic [CNT_W-1:0] input_count;
  logic [CNT_W-1:0] output_count;
  logic [3:0]       n;

  logic [CNT_W-1:0]            len_ext;
  logic [CNT_W-1:0]            len_plus;
  logic [CNT_W+20-1:0]         div_prod;
  logic [13:0]                 groups;
  logic [CNT_W-1:0]            out_len;
  logic                        put_ok;
  logic                        emit;
  logic [3:0]                  bc_grp;
  logic [3:0]                  bc_byte;
  logic [ACC_W-1:0]            grp_shift;
  logic [ACC_W-1:0]            flush_shift;
  logic [ACC_W-1:0]            byte_shift;
  logic [7:0]                  emit_val;
  logic [3:0]                  bc_emit;

  assign len_ext  = {1'b0, message_length};
  assign len_plus = len_ext + CNT_W'(4);
  assign div_prod = len_plus * DIV5_RECIP;
  assign groups   = div_prod[DIV5_SHIFT+13:DIV5_SHIFT];

  assign out_len = (mode == MODE_DEC) ? len_ext : sym_len;
  assign put_ok  = (n < MAX_RES) && (output_count < out_len);

  assign bc_grp      = bc - 4'd5;
  assign bc_byte     = bc - 4'd8;
  assign grp_shift   = acc >> bc_grp;
  assign flush_shift = acc << (4'd5 - bc);
  assign byte_shift  = acc >> bc_byte;

  always_comb begin
    emit     = 1'b0;
    emit_val = 8'd0;
    bc_emit  = bc;
    case (cmd)
      CMD_GROUP: begin
        emit     = 1'b1;
        emit_val = {3'b000, grp_shift[4:0]};
        bc_emit  = bc_grp;
      end
      CMD_FLUSH: begin
        emit     = 1'b1;
        emit_val = {3'b000, flush_shift[4:0]};
        bc_emit  = 4'd0;
      end
      CMD_ZERO: begin
        emit     = 1'b1;
      end
      CMD_BYTE: begin
        emit     = 1'b1;
        emit_val = byte_shift[7:0];
        bc_emit  = bc_byte;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    status.mode     = mode;
    status.skip     = (mode == MODE_DEC) ? (input_count >= sym_len)
                                         : (input_count >= len_ext);
    status.bc_ge5   = (bc >= 4'd5);
    status.bc_ge8   = (bc >= 4'd8);
    status.bc_part  = (bc != 4'd0) && (bc < 4'd5);
    status.enc_last = (input_count == len_ext);
    status.dec_last = (input_count == sym_len);
    status.pad_more = (n < MAX_RES) && (output_count < sym_len);
    status.out_free = !res_valid || !res_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_ENC;
      message_length <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MODE:   mode           <= wr_data[0];
        REG_LENGTH: message_length <= wr_data;
        default:    mode           <= mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_CAPTURE) begin
      word <= value;
    end
    if (cmd == CMD_SYMLEN) begin
      sym_len <= {groups, 3'b000};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      bc           <= '0;
      input_count  <= '0;
      output_count <= '0;
      n            <= '0;
    end else begin
      unique case (cmd)
        CMD_ABSORB: begin
          input_count <= input_count + CNT_W'(1);
          n           <= '0;
          if (mode == MODE_DEC) begin
            acc <= {acc[ACC_W-6:0], word[4:0]};
            bc  <= bc + 4'd5;
          end else begin
            acc <= {acc[ACC_W-9:0], word};
            bc  <= bc + 4'd8;
          end
        end
        CMD_GROUP, CMD_FLUSH, CMD_ZERO, CMD_BYTE: begin
          bc <= bc_emit;
          if (put_ok) begin
            output_count <= output_count + CNT_W'(1);
            n            <= n + 4'd1;
          end
        end
        CMD_CLEAR: begin
          acc          <= '0;
          bc           <= '0;
          input_count  <= '0;
          output_count <= '0;
        end
        default: begin
          n <= n;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit && put_ok) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && put_ok) begin
      value_res <= emit_val;
      last      <= ((output_count + CNT_W'(1)) == out_len);
    end
  end

endmodule

`default_nettype wire

@@ design/b32rg_ctrl.sv @@
// controller: sequences absorb and emit steps for one word at a time
`default_nettype none

module b32rg_ctrl
  import b32rg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    valid,
  output logic         stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_GRP   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_PAD   = 3'd5;
  localparam logic [2:0] S_BYTE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (valid) begin
          cmd        = CMD_CAPTURE;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd        = CMD_SYMLEN;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (status.skip) begin
          state_next = S_IDLE;
        end else begin
          cmd        = CMD_ABSORB;
          state_next = (status.mode == MODE_DEC) ? S_BYTE : S_GRP;
        end
      end
      S_GRP: begin
        if (status.bc_ge5) begin
          if (status.out_free) cmd = CMD_GROUP;
        end else begin
          state_next = status.enc_last ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!status.bc_part) begin
          state_next = S_PAD;
        end else if (status.out_free) begin
          cmd        = CMD_FLUSH;
          state_next = S_PAD;
        end
      end
      S_PAD: begin
        if (!status.pad_more) begin
          cmd        = CMD_CLEAR;
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd = CMD_ZERO;
        end
      end
      S_BYTE: begin
        if (status.bc_ge8) begin
          if (status.out_free) cmd = CMD_BYTE;
        end else begin
          if (status.dec_last) cmd = CMD_CLEAR;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ design/base32_symbol_regrouper.sv @@
// top level of the base32 symbol regrouper
//
// Regroups a message between 8-bit bytes and 5-bit symbol values.
// Input channel: value with valid/stall; a word is taken when valid is high
// and stall is low. Output channel: value_res and last with res_valid and
// res_stall; last marks the final result of the message.
// Configuration: wr_en, wr_index (0 mode, 1 message_length) and wr_data,
// written while the block is idle.
// Each input word goes through take, length prep, absorb, one emit per
// symbol or byte, and close; its first result is registered after the
// absorb. A word outside the message is skipped after length prep. The
// last byte of an encoded message adds a flush step if bits are left,
// zero padding and a clear step, and brings its results up to at most 8.
// The controller handles one word at a time and raises stall until done.
// Results go through a single output register; while the receiver holds
// res_stall the controller waits with the next result and nothing is lost.
// Reset clears both registers, the bit accumulator and all counters.
`default_nettype none

module base32_symbol_regrouper
  import b32rg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic             wr_index,
  input  wire logic [LEN_W-1:0] wr_data,
  input  wire logic [7:0]       value,
  input  wire logic             valid,
  output logic                  stall,
  output logic [7:0]            value_res,
  output logic                  last,
  output logic                  res_valid,
  input  wire logic             res_stall
);

  cmd_t    cmd;
  status_t status;

  b32rg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .valid  (valid),
    .stall  (stall),
    .status (status),
    .cmd    (cmd)
  );

  b32rg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .value_res (value_res),
    .last      (last),
    .res_valid (res_valid),
    .res_stall (res_stall)
  );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// self-checking testbench for the base32 symbol regrouper: directed table then random messages
module testbench
  import b32rg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG = 4000;
  localparam int N_ROWS = 34;

  typedef enum logic [1:0] {K_MODE, K_LEN, K_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [LEN_W-1:0] arg;
    logic             typed;
    logic             has_res;
    logic [7:0]       v_exp;
    logic             l_exp;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] val;
    logic       fin;
  } out_word_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             wr_en = 1'b0;
  logic             wr_index = 1'b0;
  logic [LEN_W-1:0] wr_data = '0;
  logic [7:0]       value = '0;
  logic             valid = 1'b0;
  logic             stall;
  logic [7:0]       value_res;
  logic             last;
  logic             res_valid;
  logic             res_stall = 1'b0;

  // predictor copy of registers and regrouping state
  logic cfg_mode;
  int   cfg_len;
  int   acc;
  int   nbits;
  int   in_cnt;
  int   out_cnt;
  int   burst;

  out_word_t out_q[$];
  out_word_t due;
  int        errors = 0;
  int        res_checked = 0;
  int        words_taken = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        quiet = 0;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;

  stim_row_t stim_tab [N_ROWS];

  base32_symbol_regrouper u_dut (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .value     (value),
    .valid     (valid),
    .stall     (stall),
    .value_res (value_res),
    .last      (last),
    .res_valid (res_valid),
    .res_stall (res_stall)
  );

  always #2 clk = ~clk;

  function automatic void clear_regroup();
    acc = 0;
    nbits = 0;
    in_cnt = 0;
    out_cnt = 0;
  endfunction

  function automatic void emit_result(int v, int out_len, bit record);
    if (burst >= MAX_RES || out_cnt >= out_len) return;
    out_cnt++;
    burst++;
    if (record) out_q.push_back('{v[7:0], out_cnt == out_len});
  endfunction

  // returns 0 when the word is ignored
  function automatic bit regroup_word(logic [7:0] v, bit record);
    int sym_len;
    sym_len = (cfg_len + 4) / 5 * 8;
    burst = 0;
    if (cfg_mode == MODE_ENC) begin
      if (in_cnt >= cfg_len) return 1'b0;
      in_cnt++;
      acc = ((acc << 8) | v) & 'hfff;
      nbits += 8;
      while (nbits >= 5) begin
        nbits -= 5;
        emit_result((acc >> nbits) & 'h1f, sym_len, record);
      end
      if (in_cnt == cfg_len) begin
        if (nbits > 0 && nbits < 5) emit_result((acc << (5 - nbits)) & 'h1f, sym_len, record);
        while (burst < MAX_RES && out_cnt < sym_len) emit_result(0, sym_len, record);
        clear_regroup();
      end
    end else begin
      if (in_cnt >= sym_len) return 1'b0;
      in_cnt++;
      acc = ((acc << 5) | (v & 'h1f)) & 'hfff;
      nbits += 5;
      while (nbits >= 8) begin
        nbits -= 8;
        emit_result((acc >> nbits) & 'hff, cfg_len, record);
      end
      if (in_cnt == sym_len) clear_regroup();
    end
    return 1'b1;
  endfunction

  function automatic int words_left();
    if (cfg_mode == MODE_ENC) return cfg_len - in_cnt;
    return (cfg_len + 4) / 5 * 8 - in_cnt;
  endfunction

  task automatic wait_idle();
    valid <= 1'b0;
    while (out_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [LEN_W-1:0] data);
    wait_idle();
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    if (idx == REG_MODE) cfg_mode = data[0];
    else cfg_len = int'(data);
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drive_word(input logic [7:0] v, input bit typed, input bit has_res,
                            input logic [7:0] v_exp, input logic l_exp);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      valid <= 1'b0;
      @(negedge clk);
    end
    valid <= 1'b1;
    value <= v;
    @(posedge clk);
    while (stall) @(posedge clk);
    taken = regroup_word(v, !typed);
    if (typed && has_res) out_q.push_back('{v_exp, l_exp});
    if (taken) words_taken++;
    @(negedge clk);
  endtask

  // receiver stall pattern, with one long hold-off on request
  always begin
    @(negedge clk);
    if (hold_req && !hold_done) begin
      res_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_done = 1'b1;
    end
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (out_q.size() == 0) begin
        $error("unexpected word: value_res=%0h last=%0b", value_res, last);
        errors++;
      end else begin
        due = out_q.pop_front();
        if (value_res !== due.val) begin
          $error("value_res: expected %0h, got %0h", due.val, value_res);
          errors++;
        end
        if (last !== due.fin) begin
          $error("last: expected %0b, got %0b", due.fin, last);
          errors++;
        end
        res_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || wr_en || (valid && !stall) || (res_valid && !res_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int idle_mix [4];
    int stall_mix [4];
    int goal;
    int need;
    int len;
    int roll;
    logic m;
    idle_mix = '{0, 54, 0, 14};
    stall_mix = '{0, 0, 54, 14};
    stim_tab = '{
      '{K_MODE, {15'd0, MODE_ENC}, 1'b0, 1'b0, 8'h00, 1'b0},
      // empty message: everything ignored
      '{K_LEN,  16'd0,             1'b0, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h00a5,          1'b1, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h00ff,          1'b1, 1'b0, 8'h00, 1'b0},
      '{K_LEN,  16'd1,             1'b0, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h00ff,          1'b0, 1'b0, 8'h00, 1'b0},
      // one-byte decode: padding symbols swallowed, upper bits masked
      '{K_MODE, {15'd0, MODE_DEC}, 1'b0, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h00ff,          1'b1, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h00e7,          1'b1, 1'b1, 8'hf9, 1'b1},
      '{K_WORD, 16'h0000,          1'b1, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h0020,          1'b1, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h001f,          1'b1, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h0080,          1'b1, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h0040,          1'b1, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h0000,          1'b1, 1'b0, 8'h00, 1'b0},
      // longest length, then lowered mid-message
      '{K_MODE, {15'd0, MODE_ENC}, 1'b0, 1'b0, 8'h00, 1'b0},
      '{K_LEN,  16'hffff,          1'b0, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h0000,          1'b0, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h00ff,          1'b0, 1'b0, 8'h00, 1'b0},
      '{K_LEN,  16'd2,             1'b0, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h0012,          1'b1, 1'b0, 8'h00, 1'b0},
      '{K_LEN,  16'd3,             1'b0, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h0080,          1'b0, 1'b0, 8'h00, 1'b0},
      // decode partway, then finish in encode: more than eight results due
      '{K_MODE, {15'd0, MODE_DEC}, 1'b0, 1'b0, 8'h00, 1'b0},
      '{K_LEN,  16'd5,             1'b0, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h003f,          1'b0, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h001e,          1'b0, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h0001,          1'b0, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h0015,          1'b0, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h00ea,          1'b0, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h000a,          1'b0, 1'b0, 8'h00, 1'b0},
      '{K_MODE, {15'd0, MODE_ENC}, 1'b0, 1'b0, 8'h00, 1'b0},
      '{K_LEN,  16'd7,             1'b0, 1'b0, 8'h00, 1'b0},
      '{K_WORD, 16'h00c3,          1'b0, 1'b0, 8'h00, 1'b0}
    };
    cfg_mode = MODE_ENC;
    cfg_len = 0;
    clear_regroup();

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      case (stim_tab[r].kind)
        K_MODE: write_reg(REG_MODE, stim_tab[r].arg);
        K_LEN: write_reg(REG_LENGTH, stim_tab[r].arg);
        default: drive_word(stim_tab[r].arg[7:0], stim_tab[r].typed, stim_tab[r].has_res,
                            stim_tab[r].v_exp, stim_tab[r].l_exp);
      endcase
    end

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_mix[ph];
      stall_pct = stall_mix[ph];
      if (ph == 0) hold_req = 1'b1;
      goal = words_taken + 85;
      while (words_taken < goal) begin
        roll = $urandom_range(99);
        m = $urandom_range(1) ? MODE_DEC : MODE_ENC;
        if (roll < 5) len = 0;
        else if (roll < 13) len = $urandom_range(40, 13);
        else len = $urandom_range(12, 1);
        write_reg(REG_MODE, {15'd0, m});
        write_reg(REG_LENGTH, len[LEN_W-1:0]);
        need = words_left();
        if (len == 0) begin
          need = $urandom_range(3, 1);
        end else if (need <= 0) begin
          len = in_cnt + $urandom_range(8, 1);
          write_reg(REG_LENGTH, len[LEN_W-1:0]);
          need = words_left();
        end
        // now and then a message cut short
        if ($urandom_range(9) == 0 && need > 1) need = $urandom_range(need - 1, 1);
        repeat (need) drive_word(8'($urandom_range(255)), 1'b0, 1'b0, 8'h00, 1'b0);
      end
    end

    wait_idle();
    $display("%0d words regrouped in encode and decode under four idle/stall mixes",
             words_taken);
    $display("%0d result words compared, %0d mismatches", res_checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
